### design/stq_pkg.sv
// shared types and constants for the sorted timer queue
package stq_pkg;
  localparam int NumTimers = 16;
  localparam int TickBits  = 32;
  localparam int IdxW      = $clog2(NumTimers);
  localparam int CntW      = $clog2(NumTimers + 1);

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_INIT   = 3'd1,
    ACT_START  = 3'd2,
    ACT_STOP   = 3'd3,
    ACT_RESET  = 3'd4,
    ACT_CHPER  = 3'd5,
    ACT_DELETE = 3'd6,
    ACT_NONE   = 3'd7
  } action_e;

  typedef struct packed {
    action_e             action;
    logic [IdxW-1:0]     idx;
    logic [TickBits-1:0] value;
    logic                periodic;
  } cmd_t;
endpackage

### design/stq_front.sv
// front end: accepts commands, drops ignored ones, feeds a two-entry queue
module stq_front import stq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic [2:0]  action_i,
  input  logic [3:0]  timer_index_i,
  input  logic [31:0] value_i,
  input  logic        periodic_i,
  output logic        busy,
  input  logic        pop_i,
  output logic        valid_o,
  output cmd_t        cmd_o
);
  cmd_t       mem_q [2];
  logic [1:0] cnt_q;
  logic       wptr_q, rptr_q;
  logic       push, keep;
  cmd_t       c;

  assign busy    = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rptr_q];

  always_comb begin
    c.action   = action_e'(action_i);
    c.idx      = timer_index_i[IdxW-1:0];
    c.value    = TickBits'(value_i);
    c.periodic = periodic_i;
    keep = (c.action != ACT_NONE) &&
           ((c.action == ACT_TICK) || ({28'd0, timer_index_i} < NumTimers));
  end

  assign push = start && !busy && keep;
  wire pop = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wptr_q <= 1'b0; rptr_q <= 1'b0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### design/stq_back.sv
// back end: timer state, command execution and ordered expiry scan
module stq_back import stq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  cmd_t            cmd_i,
  output logic            pop_o,
  output logic            fire_o,
  output logic [3:0]      fired_index_o,
  output logic            fired_periodic_o,
  output logic            last_o,
  output logic            idle_o
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [TickBits-1:0] now_q;
  logic [TickBits-1:0] dl_q  [NumTimers];
  logic [TickBits-1:0] per_q [NumTimers];
  logic [NumTimers-1:0] per_type_q, run_q, done_q;
  logic [IdxW-1:0]     sidx_q, best_q;
  logic                found_q;
  logic [CntW-1:0]     nfire_q;
  logic                has_prev_q;
  logic [IdxW-1:0]     prev_q;
  logic                elig, better;

  assign pop_o  = (state_q == S_IDLE) && valid_i;
  assign idle_o = (state_q == S_IDLE);

  always_comb begin
    elig   = run_q[sidx_q] && !done_q[sidx_q] && (dl_q[sidx_q] <= now_q);
    better = elig && (!found_q || dl_q[sidx_q] < dl_q[best_q]);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (pop_o && cmd_i.action == ACT_TICK) state_d = S_SCAN;
      S_SCAN: if (sidx_q == IdxW'(NumTimers - 1)) begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (found_q && nfire_q != CntW'(NumTimers)) state_d = S_SCAN;
        else state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; now_q <= '0; per_type_q <= '0; run_q <= '0;
      done_q <= '0; sidx_q <= '0; best_q <= '0; found_q <= 1'b0;
      nfire_q <= '0; has_prev_q <= 1'b0; prev_q <= '0;
      fire_o <= 1'b0; fired_index_o <= '0; fired_periodic_o <= 1'b0; last_o <= 1'b0;
      for (int i = 0; i < NumTimers; i++) begin
        dl_q[i] <= '0; per_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      fire_o  <= 1'b0;
      case (state_q)
        S_IDLE: if (pop_o) begin
          case (cmd_i.action)
            ACT_TICK: begin
              now_q <= now_q + 1'b1;
              done_q <= '0; sidx_q <= '0; found_q <= 1'b0;
              nfire_q <= '0; has_prev_q <= 1'b0;
            end
            ACT_INIT: begin
              per_q[cmd_i.idx] <= cmd_i.value; dl_q[cmd_i.idx] <= cmd_i.value;
              per_type_q[cmd_i.idx] <= cmd_i.periodic; run_q[cmd_i.idx] <= 1'b0;
            end
            ACT_START: begin
              dl_q[cmd_i.idx] <= now_q + per_q[cmd_i.idx];
              run_q[cmd_i.idx] <= 1'b1;
            end
            ACT_STOP, ACT_DELETE: run_q[cmd_i.idx] <= 1'b0;
            ACT_RESET:
              if (run_q[cmd_i.idx]) dl_q[cmd_i.idx] <= now_q + per_q[cmd_i.idx];
            ACT_CHPER: begin
              per_q[cmd_i.idx] <= cmd_i.value;
              if (run_q[cmd_i.idx]) dl_q[cmd_i.idx] <= now_q + cmd_i.value;
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (better) begin
            best_q <= sidx_q; found_q <= 1'b1;
          end
          sidx_q <= sidx_q + 1'b1;
        end
        S_EMIT: begin
          sidx_q <= '0; found_q <= 1'b0;
          if (found_q && nfire_q != CntW'(NumTimers)) begin
            // emit the previous pick, now known not to be last
            if (has_prev_q) begin
              fire_o <= 1'b1; fired_index_o <= 4'(prev_q);
              fired_periodic_o <= per_type_q[prev_q]; last_o <= 1'b0;
            end
            done_q[best_q] <= 1'b1;
            prev_q <= best_q; has_prev_q <= 1'b1;
            nfire_q <= nfire_q + 1'b1;
            if (per_type_q[best_q]) dl_q[best_q] <= now_q + per_q[best_q];
            else run_q[best_q] <= 1'b0;
          end else begin
            if (has_prev_q) begin
              fire_o <= 1'b1; fired_index_o <= 4'(prev_q);
              fired_periodic_o <= per_type_q[prev_q]; last_o <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### design/sorted_timer_queue_top.sv
// top level of the sorted timer queue
//  channel | direction | handshake
//  command | in        | start / busy
//  expiry  | out       | fire_o strobe, one cycle, no stall
// a command is queued when accepted and executed once the back end is idle and pops it.
// a tick holds the back end while it scans: one compare per cycle over all
// timers, then an emit step, for each pick.
// reset stops all timers and zeroes the time count.
// busy rises when the two-entry command queue is full.
module sorted_timer_queue_top import stq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action_i,
  input  logic [3:0]  timer_index_i,
  input  logic [31:0] value_i,
  input  logic        periodic_i,
  output logic        fire_o,
  output logic [3:0]  fired_index_o,
  output logic        fired_periodic_o,
  output logic        last_o
);
  logic pop, vld, idle;
  cmd_t cmd;

  stq_front u_front (
    .clk_i, .rst_ni, .start, .action_i, .timer_index_i, .value_i, .periodic_i,
    .busy, .pop_i(pop), .valid_o(vld), .cmd_o(cmd)
  );

  stq_back u_back (
    .clk_i, .rst_ni, .valid_i(vld), .cmd_i(cmd), .pop_o(pop),
    .fire_o, .fired_index_o, .fired_periodic_o, .last_o, .idle_o(idle)
  );

`ifndef SYNTHESIS
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> vld) else $error("pop without beat");
  a_fire_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_o |-> $past(!idle)) else $error("fire while idle");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_o && last_o) |=> !fire_o) else $error("fire after last");
`endif
endmodule

### tb/sorted_timer_queue_top_tb.sv
// self-checking testbench for the sorted timer queue: commands, ticks and expiry order
module sorted_timer_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stq_pkg::*;

  localparam int StallLimit = 5000;
  localparam int DrainCycles = 400;

  typedef struct {
    action_e     act;
    logic [3:0]  idx;
    logic [31:0] val;
    logic        per;
    logic        drain;
  } beat_t;

  typedef struct {
    logic [3:0] idx;
    logic       per;
    logic       last;
  } expiry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  action_i = ACT_TICK;
  logic [3:0]  timer_index_i = '0;
  logic [31:0] value_i = '0;
  logic        periodic_i = 1'b0;
  logic        fire_o;
  logic [3:0]  fired_index_o;
  logic        fired_periodic_o;
  logic        last_o;

  beat_t   pending[$];
  expiry_t expiries[$];
  beat_t   cur;
  int      errors = 0;
  int      gap_cnt = 0;
  bit      no_idle = 1'b0;
  int      stall_cnt = 0;

  logic [31:0] now_q;
  logic [31:0] deadline_q[NumTimers];
  logic [31:0] period_q[NumTimers];
  logic        periodic_q[NumTimers];
  logic        running_q[NumTimers];

  sorted_timer_queue_top dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void predict_expiries(beat_t b);
    logic [NumTimers-1:0] done;
    int order[NumTimers];
    int n;
    int best;
    bit found;
    expiry_t e;
    case (b.act)
      ACT_TICK: begin
        now_q = now_q + 1;
        done = '0;
        n = 0;
        while (n < NumTimers) begin
          found = 0;
          best = 0;
          for (int t = 0; t < NumTimers; t++) begin
            if (running_q[t] && !done[t] && deadline_q[t] <= now_q &&
                (!found || deadline_q[t] < deadline_q[best])) begin
              best = t;
              found = 1;
            end
          end
          if (!found) break;
          done[best] = 1'b1;
          order[n] = best;
          n++;
        end
        for (int k = 0; k < n; k++) begin
          if (periodic_q[order[k]]) deadline_q[order[k]] = now_q + period_q[order[k]];
          else running_q[order[k]] = 1'b0;
          e.idx = order[k][3:0];
          e.per = periodic_q[order[k]];
          e.last = (k == n - 1);
          expiries.push_back(e);
        end
      end
      ACT_INIT: begin
        period_q[b.idx] = b.val;
        deadline_q[b.idx] = b.val;
        periodic_q[b.idx] = b.per;
        running_q[b.idx] = 1'b0;
      end
      ACT_START: begin
        deadline_q[b.idx] = now_q + period_q[b.idx];
        running_q[b.idx] = 1'b1;
      end
      ACT_STOP, ACT_DELETE: running_q[b.idx] = 1'b0;
      ACT_RESET: begin
        if (running_q[b.idx]) deadline_q[b.idx] = now_q + period_q[b.idx];
      end
      ACT_CHPER: begin
        period_q[b.idx] = b.val;
        if (running_q[b.idx]) deadline_q[b.idx] = now_q + period_q[b.idx];
      end
      default: ;
    endcase
  endfunction

  task automatic add_beat(action_e a, int i, logic [31:0] v, logic p, logic d = 1'b0);
    beat_t b;
    b.act = a;
    b.idx = i[3:0];
    b.val = v;
    b.per = p;
    b.drain = d;
    pending.push_back(b);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      gap_cnt = 0;
    end else begin
      if (start && !busy) begin
        predict_expiries(cur);
        if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
        gap_cnt = no_idle ? 0 : $urandom_range(0, 12);
      end
      if (!start || !busy) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          start <= 1'b0;
        end else if (pending.size() > 0 && !(pending[0].drain && expiries.size() > 0)) begin
          cur = pending.pop_front();
          start <= 1'b1;
          action_i <= cur.act;
          timer_index_i <= cur.idx;
          value_i <= cur.val;
          periodic_i <= cur.per;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    expiry_t e;
    if (rst_ni) begin
      if (fire_o) begin
        if (expiries.size() == 0) begin
          $error("unexpected expiry beat: index %0d", fired_index_o);
          errors++;
        end else begin
          e = expiries.pop_front();
          if (fired_index_o !== e.idx) begin
            $error("fired_index: expected %0d, got %0d", e.idx, fired_index_o);
            errors++;
          end
          if (fired_periodic_o !== e.per) begin
            $error("fired_periodic: expected %0d, got %0d", e.per, fired_periodic_o);
            errors++;
          end
          if (last_o !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, last_o);
            errors++;
          end
        end
      end
      if ((start && !busy) || fire_o) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int r;
    int ix;
    logic [31:0] v;
    now_q = '0;
    for (int t = 0; t < NumTimers; t++) begin
      deadline_q[t] = '0;
      period_q[t] = '0;
      periodic_q[t] = 1'b0;
      running_q[t] = 1'b0;
    end

    // directed: extremes, zero period, wrapping deadline, same-deadline ties
    add_beat(ACT_TICK, 0, '0, 1'b0);
    add_beat(ACT_INIT, 15, 32'hFFFF_FFFF, 1'b1);
    add_beat(ACT_INIT, 0, 32'd0, 1'b1);
    add_beat(ACT_INIT, 3, 32'd2, 1'b0);
    add_beat(ACT_INIT, 5, 32'd2, 1'b1);
    add_beat(ACT_START, 15, '0, 1'b0);
    add_beat(ACT_START, 0, '0, 1'b0);
    add_beat(ACT_START, 5, '0, 1'b0);
    add_beat(ACT_START, 3, '0, 1'b0);
    add_beat(ACT_TICK, 7, 32'hFFFF_FFFF, 1'b1);
    add_beat(ACT_TICK, 0, '0, 1'b0);
    add_beat(ACT_RESET, 5, '0, 1'b0);
    add_beat(ACT_RESET, 3, '0, 1'b0);
    add_beat(ACT_CHPER, 0, 32'd1, 1'b0);
    add_beat(ACT_CHPER, 3, 32'd7, 1'b1);
    add_beat(ACT_NONE, 0, 32'hA5A5_5A5A, 1'b1);
    add_beat(ACT_TICK, 0, '0, 1'b0);
    add_beat(ACT_STOP, 0, '0, 1'b0);
    add_beat(ACT_DELETE, 5, '0, 1'b0);
    add_beat(ACT_TICK, 0, '0, 1'b0);
    add_beat(ACT_STOP, 15, '0, 1'b0);
    add_beat(ACT_TICK, 0, '0, 1'b0, 1'b1);

    for (int i = 0; i < 400; i++) begin
      r = $urandom_range(0, 99);
      ix = $urandom_range(0, 15);
      v = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 12);
      if (r < 40) add_beat(ACT_TICK, ix, $urandom, $urandom_range(0, 1), i == 200);
      else if (r < 55) add_beat(ACT_INIT, ix, v, $urandom_range(0, 1));
      else if (r < 75) add_beat(ACT_START, ix, $urandom, $urandom_range(0, 1));
      else if (r < 81) add_beat(ACT_STOP, ix, $urandom, $urandom_range(0, 1));
      else if (r < 88) add_beat(ACT_RESET, ix, $urandom, $urandom_range(0, 1));
      else if (r < 94) add_beat(ACT_CHPER, ix, v, $urandom_range(0, 1));
      else if (r < 98) add_beat(ACT_DELETE, ix, $urandom, $urandom_range(0, 1));
      else add_beat(ACT_NONE, ix, $urandom, $urandom_range(0, 1));
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() > 0 || start) @(posedge clk_i);
    while (expiries.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
